/* hdl/csn_pkg.sv */
// Shared types and constants for the clamped scale normaliser.
`default_nettype none
package csn_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned STEP_W = 5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } csn_state_t;

endpackage
`default_nettype wire

/* hdl/clamped_scale_normalizer.sv */
// Clamped linear normaliser: places a signed reading on a 0..FULL_SCALE scale.
//
//  Channel | Direction | Width | Contents
//  in_     | slave     | 192   | reading, scale_low, scale_high
//  out_    | master    | 16    | position
//
// A reading at or outside an end passes through one check and one hand-off
// before out_tvalid rises. Otherwise it takes one check, two passes through a
// shared 32x32 multiplier, one add, 32 restoring division steps of a single
// 65-bit subtractor and one hand-off.
// in_tready is high only while the sequencer is idle; it may accept the next
// item while a result still waits in the output register.
// rst_n is synchronous and active low; it clears the sequencer and out_tvalid.
// A stalled output holds the sequencer in its final state until taken.
`default_nettype none
module clamped_scale_normalizer #(
  parameter longint unsigned FULL_SCALE = 65535
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [63:0] reading, [127:64] scale_low, [191:128] scale_high
  input  wire logic [3*csn_pkg::VAL_W-1:0]       in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] position
  output logic [csn_pkg::POS_W-1:0]              out_tdata
);
  import csn_pkg::*;

  localparam logic [MUL_W-1:0] SCALE    = MUL_W'(FULL_SCALE);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MUL_W - 1);

  csn_state_t              state_r, state_nxt;
  logic [VAL_W-1:0]        a_r, a_nxt;      // reading, then numerator, then remainder
  logic [VAL_W-1:0]        b_r, b_nxt;      // scale_low, then low product, then quotient
  logic [VAL_W-1:0]        c_r, c_nxt;      // scale_high, then span
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [POS_W-1:0]        res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        out_data_r, out_data_nxt;

  logic [MUL_W-1:0]        mul_a;
  logic [2*MUL_W-1:0]      mul_p;
  logic [VAL_W-1:0]        shifted;
  logic [VAL_W:0]          diff;
  logic                    fits;
  logic                    in_xfer;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Shared multiplier: low half of the numerator first, then the high half
  assign mul_a = (state_r == ST_MUL_LO) ? a_r[MUL_W-1:0] : a_r[VAL_W-1:MUL_W];
  assign mul_p = mul_a * SCALE;

  // Shared restoring division step
  assign shifted = {a_r[VAL_W-2:0], b_r[MUL_W-1]};
  assign diff    = {a_r[VAL_W-1], shifted} - {1'b0, c_r};
  assign fits    = !diff[VAL_W];

  // Sequencer next state and datapath
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          a_nxt     = in_tdata[VAL_W-1:0];
          b_nxt     = in_tdata[2*VAL_W-1:VAL_W];
          c_nxt     = in_tdata[3*VAL_W-1:2*VAL_W];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ($signed(a_r) <= $signed(b_r)) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end else if ($signed(a_r) >= $signed(c_r)) begin
          res_nxt   = SCALE[POS_W-1:0];
          state_nxt = ST_DONE;
        end else begin
          a_nxt     = a_r - b_r;
          c_nxt     = c_r - b_r;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        b_nxt     = mul_p;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        a_nxt     = mul_p;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        // Top 64 product bits already lie below the span: start the remainder there
        a_nxt     = a_r + {{(VAL_W-MUL_W){1'b0}}, b_r[VAL_W-1:MUL_W]};
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        a_nxt              = fits ? diff[VAL_W-1:0] : shifted;
        b_nxt[MUL_W-1:0]   = {b_r[MUL_W-2:0], fits};
        step_nxt           = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          res_nxt   = {b_r[POS_W-2:0], fits};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    step_r     <= step_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* hdl/csn_checker.sv */
// Port-level checker for the clamped scale normaliser, with its bind.
`default_nettype none
module csn_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [csn_pkg::POS_W-1:0]     out_tdata
);
  import csn_pkg::*;

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // One item at a time: busy straight after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after input transfer");

  // A new result only comes from work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind clamped_scale_normalizer csn_checker u_csn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
